/* hw/rtl/potc_pkg.sv */
// Shared types, widths and helpers for the polygon orientation turn counter.
package potc_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int BAL_W      = 15;
  localparam int N_TURNS    = 3;

  // Turn slots: closing vertex can need up to three cross products.
  localparam int TURN_A = 0;
  localparam int TURN_B = 1;
  localparam int TURN_C = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [BAL_W-1:0]      bal_t;

  localparam bal_t BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
  localparam bal_t BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } turn_t;

  typedef struct packed {
    logic               last;
    logic               too_few;
    logic [N_TURNS-1:0] en;
  } tag_t;

  // One saturating step of the turn balance.
  function automatic bal_t sat_step(bal_t bal, turn_t t, logic en);
    bal_t r;
    r = bal;
    if (en && t.pos && (bal != BAL_MAX)) begin
      r = bal + bal_t'(1);
    end else if (en && t.neg && (bal != BAL_MIN)) begin
      r = bal - bal_t'(1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/potc_if.sv */
// Valid/ready channel interfaces for vertices in and orientation results out.
interface potc_vertex_if;
  logic                 valid;
  logic                 ready;
  potc_pkg::coord_t     x_coord;
  potc_pkg::coord_t     y_coord;
  logic                 last_vertex;

  modport source (output valid, x_coord, y_coord, last_vertex, input ready);
  modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface potc_result_if;
  logic valid;
  logic ready;
  logic positive_turns;
  logic too_few;

  modport source (output valid, positive_turns, too_few, input ready);
  modport sink   (input valid, positive_turns, too_few, output ready);
endinterface

/* hw/rtl/potc_cross_unit.sv */
// Three-stage exact cross product sign of (b-a) x (c-b).
module potc_cross_unit (
  input  logic              clk,
  input  logic              load1,
  input  logic              load2,
  input  logic              load3,
  input  potc_pkg::point_t  pa,
  input  potc_pkg::point_t  pb,
  input  potc_pkg::point_t  pc,
  output potc_pkg::turn_t   turn
);

  potc_pkg::diff_t  d1, d2, d3, d4;
  potc_pkg::prod_t  p1, p2;
  potc_pkg::cross_t cross_sum;

  assign cross_sum = potc_pkg::cross_t'(p1) - potc_pkg::cross_t'(p2);

  always_ff @(posedge clk) begin
    if (load1) begin
      d1 <= potc_pkg::diff_t'(pb.x) - potc_pkg::diff_t'(pa.x);
      d2 <= potc_pkg::diff_t'(pc.y) - potc_pkg::diff_t'(pb.y);
      d3 <= potc_pkg::diff_t'(pc.x) - potc_pkg::diff_t'(pb.x);
      d4 <= potc_pkg::diff_t'(pb.y) - potc_pkg::diff_t'(pa.y);
    end
    if (load2) begin
      p1 <= d1 * d2;
      p2 <= d3 * d4;
    end
    if (load3) begin
      turn.neg <= cross_sum[potc_pkg::CROSS_W-1];
      turn.pos <= !cross_sum[potc_pkg::CROSS_W-1] && (|cross_sum);
    end
  end

endmodule

/* hw/rtl/potc_turn_accum.sv */
// Saturating turn balance and the registered orientation result.
module potc_turn_accum (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s3_valid,
  input  potc_pkg::tag_t                              tag,
  input  potc_pkg::turn_t [potc_pkg::N_TURNS-1:0]     turns,
  output logic                                        retire,
  potc_result_if.source                               res
);

  potc_pkg::bal_t bal;
  potc_pkg::bal_t bal_next;
  logic           out_free;

  assign out_free = !res.valid || res.ready;
  // A closing vertex waits only for room in the result register.
  assign retire   = s3_valid && (!tag.last || out_free);

  always_comb begin
    bal_next = bal;
    for (int i = 0; i < potc_pkg::N_TURNS; i++) begin
      bal_next = potc_pkg::sat_step(bal_next, turns[i], tag.en[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bal       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if (retire) begin
        if (tag.last) begin
          bal       <= '0;
          res.valid <= 1'b1;
        end else begin
          bal <= bal_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && tag.last) begin
      res.positive_turns <= !tag.too_few && !bal_next[potc_pkg::BAL_W-1] && (|bal_next);
      res.too_few        <= tag.too_few;
    end
  end

endmodule

/* hw/rtl/polygon_orientation_turn_count.sv */
// Top level: polygon orientation by counting signed turns over a vertex stream.
//
// Usage: vertices enter on vtx, one beat per vertex, x_coord/y_coord as signed
// 32-bit integers; last_vertex marks the closing vertex of a polygon. A closing
// vertex equal to the first one is treated as a repeat and dropped. Exactly one
// beat leaves on res per polygon, carrying positive_turns (more left turns than
// right turns) and too_few (polygon of one or two vertices).
// Throughput: one vertex per cycle, sustained while res is not stalled, including the
// closing vertex, since three cross product units work side by side.
// The result of a polygon reaches res through the difference, product, sign and
// result registers after its closing vertex is accepted.
// Reset (rst, synchronous) empties the pipeline, drops any pending result and
// starts a new polygon. When res is stalled, the pipeline keeps taking vertices
// until a closing vertex reaches the balance stage; then vtx.ready falls once
// the three pipeline stages ahead of it are full.
module polygon_orientation_turn_count (
  input  logic         clk,
  input  logic         rst,
  potc_vertex_if.sink  vtx,
  potc_result_if.source res
);

  potc_pkg::point_t first, second, older, recent, pt;
  logic [1:0]       cnt;
  logic             accept, rpt, enough;

  logic             s1_valid, s2_valid, s3_valid;
  logic             s1_ready, s2_ready, s3_ready;
  logic             load2, load3, retire;
  potc_pkg::tag_t   tag_in, tag1, tag2, tag3;

  potc_pkg::point_t [potc_pkg::N_TURNS-1:0] pa, pb, pc;
  potc_pkg::turn_t  [potc_pkg::N_TURNS-1:0] turns;

  assign pt     = '{x: vtx.x_coord, y: vtx.y_coord};
  assign rpt    = (pt == first);
  assign enough = (cnt == 2'd2);

  // Hand-off chain: each stage frees when its successor takes it.
  assign s3_ready  = !s3_valid || retire;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign vtx.ready = s1_ready;
  assign accept    = vtx.valid && vtx.ready;
  assign load2     = s1_valid && s2_ready;
  assign load3     = s2_valid && s3_ready;

  always_comb begin
    tag_in.last            = vtx.last_vertex;
    tag_in.too_few         = vtx.last_vertex && !enough;
    tag_in.en              = '0;
    tag_in.en[potc_pkg::TURN_A] = enough;
    tag_in.en[potc_pkg::TURN_B] = enough && vtx.last_vertex;
    tag_in.en[potc_pkg::TURN_C] = enough && vtx.last_vertex && !rpt;

    pa[potc_pkg::TURN_A] = older;
    pb[potc_pkg::TURN_A] = recent;
    pc[potc_pkg::TURN_A] = pt;
    // On a repeated closing vertex, pt equals first here.
    pa[potc_pkg::TURN_B] = recent;
    pb[potc_pkg::TURN_B] = pt;
    pc[potc_pkg::TURN_B] = rpt ? second : first;
    pa[potc_pkg::TURN_C] = pt;
    pb[potc_pkg::TURN_C] = first;
    pc[potc_pkg::TURN_C] = second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= 2'd0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (vtx.last_vertex) begin
          cnt <= 2'd0;
        end else if (!enough) begin
          cnt <= cnt + 2'd1;
        end
      end
      if (s1_ready) begin
        s1_valid <= accept;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag1 <= tag_in;
      if (!vtx.last_vertex) begin
        if (cnt == 2'd0) begin
          first <= pt;
        end
        if (cnt == 2'd1) begin
          second <= pt;
        end
        older  <= recent;
        recent <= pt;
      end
    end
    if (load2) begin
      tag2 <= tag1;
    end
    if (load3) begin
      tag3 <= tag2;
    end
  end

  for (genvar g = 0; g < potc_pkg::N_TURNS; g++) begin : g_cross
    potc_cross_unit u_cross (
      .clk   (clk),
      .load1 (accept),
      .load2 (load2),
      .load3 (load3),
      .pa    (pa[g]),
      .pb    (pb[g]),
      .pc    (pc[g]),
      .turn  (turns[g])
    );
  end

  potc_turn_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .s3_valid (s3_valid),
    .tag      (tag3),
    .turns    (turns),
    .retire   (retire),
    .res      (res)
  );

  a_too_few_not_positive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.too_few |-> !res.positive_turns)
    else $error("too_few result reports positive turns");

  a_too_few_no_turns: assert property (@(posedge clk) disable iff (rst)
    s3_valid && tag3.too_few |-> tag3.last && (tag3.en == '0))
    else $error("short polygon carries enabled turns");

  a_third_turn_closing: assert property (@(posedge clk) disable iff (rst)
    s1_valid && tag1.en[potc_pkg::TURN_C] |-> tag1.last && tag1.en[potc_pkg::TURN_B])
    else $error("third cross product enabled outside a closing vertex");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !s1_valid && !s2_valid && !s3_valid && !res.valid)
    else $error("pipeline not empty after reset");

endmodule

/* test/tb.sv */
// Self-checking bench for the polygon turn counter: random vertex streams, stalls, predictor.
module tb;

  localparam int MAX_VERTICES   = 8192;
  localparam int RANDOM_BEATS   = 1550;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam potc_pkg::coord_t C_MAX = 32'sh7fffffff;
  localparam potc_pkg::coord_t C_MIN = 32'sh80000000;

  typedef enum int {STYLE_FULL, STYLE_TINY, STYLE_EXTREME, STYLE_MIXED} coord_style_t;

  typedef struct {
    potc_pkg::coord_t x;
    potc_pkg::coord_t y;
    logic             last;
  } vertex_beat_t;

  typedef struct {
    logic pos;
    logic too_few;
  } orient_result_t;

  logic clk;
  logic rst;

  potc_vertex_if vtx_ch ();
  potc_result_if res_ch ();

  polygon_orientation_turn_count dut (
    .clk (clk),
    .rst (rst),
    .vtx (vtx_ch),
    .res (res_ch)
  );

  // Stimulus and expectations
  vertex_beat_t   vertex_queue[$];
  orient_result_t orient_expected[$];
  int beats_queued;
  int beats_taken;

  // Predictor state for the polygon being received
  potc_pkg::point_t first_pt, second_pt, older_pt, recent_pt;
  int               turn_balance;
  int               vertices_seen;

  // Run statistics
  int mismatches;
  int polygons_checked;
  int short_polygons;
  int positive_polygons;

  // Sign of (b-a) x (c-b); all terms fit in 67 signed bits.
  function automatic int turn_sign(potc_pkg::point_t a, potc_pkg::point_t b,
                                   potc_pkg::point_t c);
    logic signed [66:0] ax, ay, bx, by, cx, cy, cr;
    ax = a.x; ay = a.y;
    bx = b.x; by = b.y;
    cx = c.x; cy = c.y;
    cr = (bx - ax) * (cy - by) - (cx - bx) * (by - ay);
    if (cr > 0) return 1;
    if (cr < 0) return -1;
    return 0;
  endfunction

  task automatic add_turn(int s);
    if (s > 0 && turn_balance < int'(potc_pkg::BAL_MAX)) turn_balance++;
    else if (s < 0 && turn_balance > int'(potc_pkg::BAL_MIN)) turn_balance--;
  endtask

  task automatic clear_polygon();
    first_pt      = '0;
    second_pt     = '0;
    older_pt      = '0;
    recent_pt     = '0;
    turn_balance  = 0;
    vertices_seen = 0;
  endtask

  // Advance the predictor by one accepted vertex beat.
  task automatic predict_vertex(vertex_beat_t v);
    potc_pkg::point_t p;
    orient_result_t   r;
    p.x = v.x;
    p.y = v.y;
    if (!v.last) begin
      if (vertices_seen == 0) first_pt = p;
      else if (vertices_seen == 1) second_pt = p;
      else add_turn(turn_sign(older_pt, recent_pt, p));
      older_pt  = recent_pt;
      recent_pt = p;
      if (vertices_seen < MAX_VERTICES) vertices_seen++;
    end else begin
      if (vertices_seen < 2) begin
        r.pos     = 1'b0;
        r.too_few = 1'b1;
      end else begin
        if (p == first_pt) begin
          // closing repeat of the first vertex: drop it
          add_turn(turn_sign(older_pt, recent_pt, first_pt));
          add_turn(turn_sign(recent_pt, first_pt, second_pt));
        end else begin
          add_turn(turn_sign(older_pt, recent_pt, p));
          add_turn(turn_sign(recent_pt, p, first_pt));
          add_turn(turn_sign(p, first_pt, second_pt));
        end
        r.pos     = (turn_balance > 0);
        r.too_few = 1'b0;
      end
      orient_expected.push_back(r);
      clear_polygon();
    end
  endtask

  task automatic push_vertex(potc_pkg::coord_t x, potc_pkg::coord_t y, logic last);
    vertex_queue.push_back('{x, y, last});
    beats_queued++;
  endtask

  // Repeat a triangle one way, then the other way, so the balance climbs and falls.
  task automatic push_winding(int n_ccw, int n_cw);
    potc_pkg::point_t tri_ccw[3];
    potc_pkg::point_t tri_cw[3];
    int               total;
    int               i;
    tri_ccw[0] = '{x: 0,    y: 0};
    tri_ccw[1] = '{x: 5000, y: 0};
    tri_ccw[2] = '{x: 0,    y: 5000};
    tri_cw[0]  = tri_ccw[0];
    tri_cw[1]  = tri_ccw[2];
    tri_cw[2]  = tri_ccw[1];
    total = n_ccw + n_cw;
    for (i = 0; i < total; i++) begin
      if (i < n_ccw) push_vertex(tri_ccw[i % 3].x, tri_ccw[i % 3].y, i == total - 1);
      else push_vertex(tri_cw[(i - n_ccw) % 3].x, tri_cw[(i - n_ccw) % 3].y,
                       i == total - 1);
    end
  endtask

  function automatic potc_pkg::coord_t pick_coord(coord_style_t s);
    coord_style_t k;
    k = s;
    if (k == STYLE_MIXED) k = coord_style_t'($urandom_range(0, 2));
    case (k)
      STYLE_TINY: return potc_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 6))
          0: return C_MAX;
          1: return C_MIN;
          2: return potc_pkg::coord_t'(0);
          3: return potc_pkg::coord_t'(-1);
          4: return potc_pkg::coord_t'(1);
          5: return C_MAX - 1;
          default: return C_MIN + 1;
        endcase
      end
      default: return potc_pkg::coord_t'($urandom);
    endcase
  endfunction

  // One random polygon: mostly short, some long, some closed on a repeat of the first vertex.
  task automatic push_random_polygon();
    coord_style_t     style;
    potc_pkg::coord_t fx, fy, x, y;
    int               nv;
    int               k;
    logic             close_rpt;
    style = coord_style_t'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) nv = $urandom_range(1, 2);
    else if ($urandom_range(0, 5) == 0) nv = $urandom_range(20, 60);
    else nv = $urandom_range(3, 12);
    close_rpt = (nv >= 3) && ($urandom_range(0, 3) == 0);
    fx = pick_coord(style);
    fy = pick_coord(style);
    for (k = 0; k < nv; k++) begin
      if (k == 0 || (k == nv - 1 && close_rpt)) begin
        x = fx;
        y = fy;
      end else begin
        x = pick_coord(style);
        y = pick_coord(style);
      end
      push_vertex(x, y, k == nv - 1);
    end
  endtask

  // Hold new stimulus until every queued beat is taken and every result is back.
  task automatic wait_drained();
    while (beats_taken != beats_queued || orient_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps.
  vertex_beat_t on_wire;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      vtx_ch.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (vtx_ch.valid && vtx_ch.ready) begin
        predict_vertex(on_wire);
        beats_taken++;
      end
      if (!(vtx_ch.valid && !vtx_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          vtx_ch.valid <= 1'b0;
        end else if (vertex_queue.size() > 0) begin
          on_wire             = vertex_queue.pop_front();
          vtx_ch.x_coord     <= on_wire.x;
          vtx_ch.y_coord     <= on_wire.y;
          vtx_ch.last_vertex <= on_wire.last;
          vtx_ch.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          vtx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a random 16-bit pattern, stepped by a free-running tick and redrawn when the tick wraps.
  logic [15:0] stall_pattern;
  logic [6:0]  stall_tick;

  always @(posedge clk) begin
    if (rst) begin
      stall_tick    <= 7'd0;
      stall_pattern <= 16'hffff;
      res_ch.ready  <= 1'b1;
    end else begin
      stall_tick   <= stall_tick + 7'd1;
      res_ch.ready <= stall_pattern[stall_tick[3:0]];
      if (stall_tick == 7'd127) begin
        if ($urandom_range(0, 3) == 0) stall_pattern <= 16'hffff;
        else stall_pattern <= 16'($urandom) | 16'h0001;
      end
    end
  end

  // Result checker
  orient_result_t seen_res;
  orient_result_t want_res;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_res.pos     = res_ch.positive_turns;
      seen_res.too_few = res_ch.too_few;
      if (orient_expected.size() == 0) begin
        $display("%0t: result beat with none expected: positive_turns %0b too_few %0b",
                 $time, seen_res.pos, seen_res.too_few);
        mismatches++;
      end else begin
        want_res = orient_expected.pop_front();
        if (seen_res.pos !== want_res.pos) begin
          $display("%0t: positive_turns expected %0b actual %0b",
                   $time, want_res.pos, seen_res.pos);
          mismatches++;
        end
        if (seen_res.too_few !== want_res.too_few) begin
          $display("%0t: too_few expected %0b actual %0b",
                   $time, want_res.too_few, seen_res.too_few);
          mismatches++;
        end
        polygons_checked++;
        if (want_res.too_few) short_polygons++;
        if (want_res.pos) positive_polygons++;
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    clear_polygon();

    // Directed shapes: short polygons, closing repeats, extremes, collinear points.
    push_vertex(32'sd1, 32'sd2, 1'b1);
    push_vertex(32'sd0, 32'sd0, 1'b0);
    push_vertex(32'sd5, 32'sd5, 1'b1);
    push_vertex(32'sd0, 32'sd0, 1'b0);
    push_vertex(32'sd10, 32'sd0, 1'b0);
    push_vertex(32'sd0, 32'sd10, 1'b1);
    push_vertex(32'sd0, 32'sd0, 1'b0);
    push_vertex(32'sd10, 32'sd0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 1'b1);
    push_vertex(32'sd0, 32'sd0, 1'b0);
    push_vertex(32'sd0, 32'sd10, 1'b0);
    push_vertex(32'sd10, 32'sd10, 1'b0);
    push_vertex(32'sd10, 32'sd0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 1'b1);
    push_vertex(C_MAX, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MIN, 1'b1);
    push_vertex(C_MAX, C_MIN, 1'b0);
    push_vertex(C_MIN, C_MAX, 1'b0);
    push_vertex(C_MAX, C_MAX, 1'b1);
    push_vertex(32'sd0, 32'sd0, 1'b0);
    push_vertex(32'sd1, 32'sd1, 1'b0);
    push_vertex(32'sd2, 32'sd2, 1'b1);
    push_winding(40, 30);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Let the directed shapes finish before the random stream starts.
    wait_drained();

    while (beats_queued < RANDOM_BEATS / 2) push_random_polygon();
    wait_drained();
    while (beats_queued < RANDOM_BEATS) push_random_polygon();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d vertex beats in %0d polygons under bursty input and stalled output.",
             beats_taken, polygons_checked);
    $display("Short polygons %0d, positive orientation %0d, mismatches %0d.",
             short_polygons, positive_polygons, mismatches);
    if (mismatches == 0 && orient_expected.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
